// ===== hw/rtl/elev_sched_pkg.sv =====
// Shared types, constants and codes for the elevator stop scheduler.
package elev_sched_pkg;

    localparam int FLOOR_SLOTS = 64;
    localparam int SLOT_W      = $clog2(FLOOR_SLOTS);
    localparam int FLOOR_W     = 6;
    localparam int COUNT_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_DATA_W   = 8;
    localparam int OUT_DATA_W  = 16;
    localparam int SLOT_OFFSET = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;

    localparam logic FUNC_REQUEST = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        ST_ACCEPTED     = 3'd0,
        ST_AGAINST_UP   = 3'd1,
        ST_AGAINST_DOWN = 3'd2,
        ST_NO_FLOOR     = 3'd3,
        ST_FULL         = 3'd4,
        ST_MOVED        = 3'd5,
        ST_IDLE         = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_READ   = 2'd1,
        S_UPDATE = 2'd2
    } state_t;

    typedef struct packed {
        logic latch;
        logic read;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/elev_sched_ctrl.sv =====
// Controller state machine of the elevator stop scheduler.
module elev_sched_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  elev_sched_pkg::sts_t sts,
    output elev_sched_pkg::cmd_t cmd
);
    import elev_sched_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                // hold until the output register can take the result
                if (sts.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/elev_sched_dp.sv =====
// Datapath of the elevator stop scheduler: count memory, car state, output register.
module elev_sched_dp (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [elev_sched_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [elev_sched_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [elev_sched_pkg::IN_DATA_W-1:0]       s_tdata,
    input  logic                                       s_tuser,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [elev_sched_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic [2:0]                                 m_tuser,
    input  elev_sched_pkg::cmd_t                       cmd,
    output elev_sched_pkg::sts_t                       sts
);
    import elev_sched_pkg::*;

    // configuration
    logic signed [FLOOR_W-1:0] lowest_reg;
    logic signed [FLOOR_W-1:0] highest_reg;
    logic [COUNT_W-1:0]        capacity_reg;

    // car state
    logic signed [FLOOR_W-1:0] pos_reg;
    logic signed [FLOOR_W-1:0] pos_next;
    logic                      up_reg;
    logic                      up_next;
    logic [COUNT_W-1:0]        riders_reg;
    logic [COUNT_W-1:0]        riders_next;
    logic [FLOOR_SLOTS-1:0]    nz_reg;

    // item in work
    logic                      func_reg;
    logic signed [FLOOR_W-1:0] floor_reg;
    logic [SLOT_W-1:0]         addr_reg;
    logic [COUNT_W-1:0]        rd_data_reg;
    logic                      found_reg;

    // output register
    logic                      out_valid_reg;
    logic [OUT_DATA_W-1:0]     out_data_reg;
    logic [2:0]                out_user_reg;

    logic [COUNT_W-1:0]        count_mem [FLOOR_SLOTS];

    logic [FLOOR_W:0]          slot_ext;
    logic                      slot_ok;
    logic [SLOT_W-1:0]         pick;
    logic [SLOT_W-1:0]         rd_addr;
    logic [COUNT_W-1:0]        count_eff;
    logic [COUNT_W-1:0]        count_inc;
    logic                      mem_we;
    logic                      nz_set;
    logic                      nz_clr;
    status_t                   status;

    // lowest nonzero slot when heading up, highest when heading down
    function automatic logic [SLOT_W-1:0] pick_slot(input logic [FLOOR_SLOTS-1:0] nz,
                                                     input logic up);
        logic [SLOT_W-1:0] p;
        p = '0;
        if (up)
        begin
            for (int i = FLOOR_SLOTS - 1; i >= 0; i--)
            begin
                if (nz[i])
                begin
                    p = SLOT_W'(i);
                end
            end
        end
        else
        begin
            for (int i = 0; i < FLOOR_SLOTS; i++)
            begin
                if (nz[i])
                begin
                    p = SLOT_W'(i);
                end
            end
        end
        return p;
    endfunction

    // slot of floor f is f + 32; flipping the sign bit gives that offset
    assign slot_ext = {1'b0, ~floor_reg[FLOOR_W-1], floor_reg[FLOOR_W-2:0]};
    assign slot_ok  = (32'(slot_ext) < FLOOR_SLOTS);
    assign pick     = pick_slot(nz_reg, up_reg);
    assign rd_addr  = (func_reg == FUNC_ADVANCE) ? pick : SLOT_W'(slot_ext);

    // an entry whose nonzero bit is clear reads as zero
    assign count_eff = nz_reg[addr_reg] ? rd_data_reg : '0;
    assign count_inc = (count_eff == '1) ? count_eff : count_eff + 1'b1;

    always_comb
    begin
        pos_next    = pos_reg;
        up_next     = up_reg;
        riders_next = riders_reg;
        mem_we      = 1'b0;
        nz_set      = 1'b0;
        nz_clr      = 1'b0;
        status      = ST_ACCEPTED;
        if (func_reg == FUNC_REQUEST)
        begin
            if (riders_reg >= capacity_reg)
            begin
                status = ST_FULL;
            end
            else if (riders_reg != '0 && up_reg && floor_reg < pos_reg)
            begin
                status = ST_AGAINST_UP;
            end
            else if (riders_reg != '0 && !up_reg && floor_reg > pos_reg)
            begin
                status = ST_AGAINST_DOWN;
            end
            else if (floor_reg > highest_reg || floor_reg < lowest_reg || !slot_ok)
            begin
                status = ST_NO_FLOOR;
            end
            else
            begin
                status = ST_ACCEPTED;
                mem_we = 1'b1;
                nz_set = 1'b1;
                // an empty car takes its heading from the first request
                if (riders_reg == '0)
                begin
                    if (floor_reg > pos_reg)
                    begin
                        up_next = 1'b1;
                    end
                    else if (floor_reg < pos_reg)
                    begin
                        up_next = 1'b0;
                    end
                end
                if (riders_reg != '1)
                begin
                    riders_next = riders_reg + 1'b1;
                end
            end
        end
        else if (!found_reg)
        begin
            status = ST_IDLE;
        end
        else
        begin
            status = ST_MOVED;
            nz_clr = 1'b1;
            riders_next = (riders_reg >= count_eff) ? riders_reg - count_eff : '0;
            pos_next = FLOOR_W'(32'(addr_reg) - SLOT_OFFSET);
            if (pos_next == highest_reg)
            begin
                up_next = 1'b0;
            end
            else if (pos_next == lowest_reg)
            begin
                up_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg    <= '0;
            highest_reg   <= FLOOR_W'(15);
            capacity_reg  <= COUNT_W'(8);
            pos_reg       <= '0;
            up_reg        <= 1'b1;
            riders_reg    <= '0;
            nz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LOWEST:   lowest_reg   <= cfg_data[FLOOR_W-1:0];
                    CFG_HIGHEST:  highest_reg  <= cfg_data[FLOOR_W-1:0];
                    CFG_CAPACITY: capacity_reg <= cfg_data[COUNT_W-1:0];
                    default:      ;
                endcase
            end
            if (cmd.update)
            begin
                pos_reg    <= pos_next;
                up_reg     <= up_next;
                riders_reg <= riders_next;
                if (nz_set)
                begin
                    nz_reg[addr_reg] <= 1'b1;
                end
                if (nz_clr)
                begin
                    nz_reg[addr_reg] <= 1'b0;
                end
            end
            if (cmd.update)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            func_reg  <= s_tuser;
            floor_reg <= s_tdata[FLOOR_W-1:0];
        end
        if (cmd.read)
        begin
            addr_reg    <= rd_addr;
            rd_data_reg <= count_mem[rd_addr];
            found_reg   <= |nz_reg;
        end
        if (cmd.update)
        begin
            out_user_reg <= status;
            out_data_reg <= {1'b0, up_next, riders_next, pos_next};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && mem_we)
        begin
            count_mem[addr_reg] <= count_inc;
        end
    end

    assign sts.out_free = !out_valid_reg || m_tready;
    assign m_tvalid     = out_valid_reg;
    assign m_tdata      = out_data_reg;
    assign m_tuser      = out_user_reg;

endmodule

// ===== hw/rtl/elevator_stop_scheduler.sv =====
// Top level of the elevator stop scheduler: controller plus datapath.
//
// Input s_*: one item per handshake; s_tuser selects the work (0 = destination
//   request, 1 = advance to the next stop), s_tdata[5:0] holds the signed
//   destination floor, ignored for an advance.
// Output m_*: exactly one result item per input item, in order; m_tuser holds
//   the status code, m_tdata the car floor, occupant count and heading after
//   the item.
// Configuration: pulse cfg_we with cfg_index (0 lowest floor, 1 highest floor,
//   2 car capacity) and cfg_data only while no item is in work.
// Sequence: acceptance latches the item, then the count memory is read (for an
//   advance the stop is picked by a priority encoder over the nonzero-count
//   bitmap), then the car is updated and the output register loaded once it
//   is free. One item is in work at a time: the next item is accepted only
//   after the result of the last one is loaded.
// Reset: rst_n puts the car at floor zero, heading up, empty, with all floor
//   counts reading zero (per-slot nonzero bits clear at once; no sweep).
// Stall: a result waits in the output register; the next item is still
//   accepted, and its update holds until the output register frees up, with
//   s_tready low meanwhile.
module elevator_stop_scheduler (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       cfg_we,
    input  logic [elev_sched_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [elev_sched_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [elev_sched_pkg::IN_DATA_W-1:0]       s_tdata,   // [5:0] floor, [7:6] zero
    input  logic                                       s_tuser,   // [0] func
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [elev_sched_pkg::OUT_DATA_W-1:0]      m_tdata,   // [5:0] car_floor,
                                                                  // [13:6] occupants,
                                                                  // [14] moving_up,
                                                                  // [15] zero
    output logic [2:0]                                 m_tuser    // [2:0] status
);
    import elev_sched_pkg::*;

    cmd_t cmd;
    sts_t sts;

    elev_sched_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    elev_sched_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
